/* design/cursor_sequence_store_macros.svh */
// ----------------------------------------------------------------------------
// Cursor sequence store assertion macros
// Shared clocked assertion forms used by the store's modules.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_STORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_MACROS_SVH

// Property sampled on the rising clock edge, masked while reset is held.
`define CSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/css_pkg.sv */
// ----------------------------------------------------------------------------
// css_pkg
// Opcodes, status codes, controller states and command types of the store.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REPORT_W = 6;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OUT_W    = 48;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_ADV    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ATTACH = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOITEM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;  // latch the accepted request
    logic exec;     // apply the opcode to store, count and cursor
    logic capture;  // load the result register
  } cmd_t;

endpackage

`default_nettype wire

/* design/css_datapath.sv */
// ----------------------------------------------------------------------------
// css_datapath
// Word register chain with count and cursor, opcode execution and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_sequence_store_macros.svh"

module css_datapath #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire css_pkg::cmd_t                       cmd,
  input  wire logic [css_pkg::OP_W-1:0]            in_op,
  input  wire logic [css_pkg::IN_W-1:0]            in_value,
  output logic      [css_pkg::OUT_W-1:0]           out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [css_pkg::OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0]          val_r;
  logic [DATA_WIDTH-1:0]          words_r   [CAPACITY];
  logic [DATA_WIDTH-1:0]          words_nxt [CAPACITY];
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               cursor_r, cursor_nxt;
  css_pkg::status_t               status_r, status_nxt;

  logic [CNT_W-1:0]               pos;
  logic                           do_ins, do_rem;
  logic                           has_cur, full;

  logic [DATA_WIDTH+css_pkg::IN_W-1:0]   val_ext;
  logic [DATA_WIDTH+css_pkg::WORD_W-1:0] word_ext;
  logic [CNT_W+css_pkg::REPORT_W-1:0]    count_ext, cursor_ext;
  logic [DATA_WIDTH-1:0]                 cur_word;

  css_pkg::status_t                  out_status_r;
  logic [css_pkg::REPORT_W-1:0]      out_count_r, out_cursor_r;
  logic                              out_has_r;
  logic [css_pkg::WORD_W-1:0]        out_word_r;

  assign val_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign has_cur = cursor_r < count_r;
  assign full    = count_r == CNT_W'(CAPACITY);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      val_r <= val_ext[DATA_WIDTH-1:0];
    end
  end

  always_comb begin
    pos        = cursor_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = css_pkg::ST_DONE;
    unique case (op_r)
      css_pkg::OP_START: begin
        cursor_nxt = '0;
      end
      css_pkg::OP_ADV: begin
        if (has_cur) cursor_nxt = CNT_W'(cursor_r + 1'b1);
        else         status_nxt = css_pkg::ST_NOITEM;
      end
      css_pkg::OP_INSERT, css_pkg::OP_ATTACH: begin
        if (full) begin
          status_nxt = css_pkg::ST_FULL;
        end else begin
          if (op_r == css_pkg::OP_INSERT) pos = has_cur ? cursor_r : '0;
          else pos = has_cur ? CNT_W'(cursor_r + 1'b1) : count_r;
          do_ins     = 1'b1;
          cursor_nxt = pos;
          count_nxt  = CNT_W'(count_r + 1'b1);
        end
      end
      css_pkg::OP_REMOVE: begin
        if (has_cur) begin
          do_rem    = 1'b1;
          count_nxt = CNT_W'(count_r - 1'b1);
        end else begin
          status_nxt = css_pkg::ST_NOITEM;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_word
    localparam logic [CNT_W-1:0] GI = CNT_W'(g);
    always_comb begin
      words_nxt[g] = words_r[g];
      if (do_ins) begin
        if (GI == pos)     words_nxt[g] = val_r;
        else if (GI > pos) words_nxt[g] = words_r[(g > 0) ? g - 1 : 0];
      end else if (do_rem) begin
        if (GI >= pos)     words_nxt[g] = words_r[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) words_r <= words_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      status_r <= css_pkg::ST_DONE;
    end else if (cmd.exec) begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      status_r <= status_nxt;
    end
  end

  assign cur_word   = has_cur ? words_r[cursor_r[IDX_W-1:0]] : '0;
  assign word_ext   = {{css_pkg::WORD_W{1'b0}}, cur_word};
  assign count_ext  = {{css_pkg::REPORT_W{1'b0}}, count_r};
  assign cursor_ext = {{css_pkg::REPORT_W{1'b0}}, cursor_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_status_r <= status_r;
      out_count_r  <= count_ext[css_pkg::REPORT_W-1:0];
      out_cursor_r <= cursor_ext[css_pkg::REPORT_W-1:0];
      out_has_r    <= has_cur;
      out_word_r   <= word_ext[css_pkg::WORD_W-1:0];
    end
  end

  assign out_data = {1'b0, out_word_r, out_has_r, out_cursor_r, out_count_r, out_status_r};

  `CSS_ASSERT(a_cursor_in_range, cursor_r <= count_r, "cursor beyond count")
  `CSS_ASSERT_NEXT(a_full_holds, cmd.exec && full &&
    (op_r == css_pkg::OP_INSERT || op_r == css_pkg::OP_ATTACH),
    $stable(count_r) && status_r == css_pkg::ST_FULL, "full store changed")
  `CSS_ASSERT_NEXT(a_idle_stable, !cmd.exec, $stable(count_r) && $stable(cursor_r),
    "state changed outside exec")

endmodule

`default_nettype wire

/* design/css_ctrl.sv */
// ----------------------------------------------------------------------------
// css_ctrl
// Request sequencer: accept, execute, load result, and output valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_sequence_store_macros.svh"

module css_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output css_pkg::cmd_t      cmd
);

  css_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= css_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      css_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = css_pkg::S_EXEC;
        end
      end
      css_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = css_pkg::S_READ;
      end
      css_pkg::S_READ: begin
        if (!out_valid_r || out_tready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = css_pkg::S_IDLE;
        end
      end
      default: state_nxt = css_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

  `CSS_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, cmd.exec, "no exec after accept")
  `CSS_ASSERT(a_no_overwrite, !(cmd.capture && out_valid_r && !out_tready),
    "result overwritten while stalled")
  `CSS_ASSERT_NEXT(a_capture_valid, cmd.capture, out_tvalid, "captured result not shown")

endmodule

`default_nettype wire

/* design/cursor_sequence_store.sv */
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Ordered word store with a cursor, driven by one opcode per request.
// ----------------------------------------------------------------------------
// Input channel in_*: one request per handshake, in_tuser carries the opcode
// (start, advance, insert, attach, remove), in_tdata the word to store.
// Output channel out_*: exactly one result per request, in request order,
// with status, count, cursor position, cursor-valid flag and current word.
// A request is accepted in the idle state, executed in the execute state, and
// its result is loaded in the read state once the output register is free;
// out_tvalid rises with that load. Requests pass through the accept / execute /
// load sequence one at a time; in_tready is high in the idle state only.
// All stored words shift at once, in a register chain of CAPACITY words.
// A waiting result does not block the next request: it is accepted and
// executed, and its result is held back until out_tready takes the pending one.
// Reset: count and cursor go to zero, no result pending, store contents are
// left as they are and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_store #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] entry_value
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [1:0] status, [7:2] count, [13:8] cursor_pos,
                                       // [14] has_current, [46:15] current_word, [47] zero
);

  css_pkg::cmd_t cmd;

  css_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  css_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_tuser),
    .in_value (in_tdata),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire
